// ----- rtl/core/shmm_pkg.sv -----
`default_nettype none

package shmm_pkg;

	localparam int PIXEL_BITS = 12;
	localparam int COUNT_BITS = 24;
	localparam int NBINS_BITS = PIXEL_BITS + 1;

	localparam logic [1:0] CMD_PIXEL = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef struct packed {
		logic [1:0]            cmd;
		logic [PIXEL_BITS-1:0] pixel_value;
		logic [PIXEL_BITS-1:0] bin_offset;
	} req_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] bin_value;
		logic [COUNT_BITS-1:0] bin_count;
		logic [PIXEL_BITS-1:0] slice_minimum;
		logic [PIXEL_BITS-1:0] slice_maximum;
		logic [NBINS_BITS-1:0] number_of_bins;
		logic                  out_of_range;
	} rsp_t;

	// everything a read returns except the count
	typedef struct packed {
		logic [PIXEL_BITS-1:0] bin_value;
		logic [PIXEL_BITS-1:0] slice_minimum;
		logic [PIXEL_BITS-1:0] slice_maximum;
		logic [NBINS_BITS-1:0] number_of_bins;
		logic                  out_of_range;
	} rd_info_t;

	typedef struct packed {
		logic                  clear;
		logic                  pixel;
		logic [PIXEL_BITS-1:0] pixel_value;
	} stats_upd_t;

endpackage

`default_nettype wire

// ----- rtl/core/slice_histogram_min_max.sv -----
// channel | signals                    | moves
// --------+----------------------------+------------------------------------
// request | req_valid, req_ready, req  | cmd, pixel_value, bin_offset
// result  | res_valid, res_ready, res  | one result per read request
//
// One request a cycle: the bin is read at acceptance, bumped in the next cycle
// and written back; a same-bin follower takes the bumped count by forwarding.
// A read result lands in a one-deep output register; while it waits and the
// following read sits in the bump stage, requests are held off.
// After reset and after each clear the bin memory is zeroed one entry a cycle
// through all 4096 entries, and no request is accepted while this runs.
`default_nettype none

module slice_histogram_min_max
	import shmm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      res_valid,
	input  wire logic res_ready,
	output rsp_t      res
);

	logic accept;
	logic is_pixel;
	logic is_read;
	logic is_clear;

	logic                  clr_busy_q;
	logic [PIXEL_BITS-1:0] clr_addr_q;

	logic                  valid_s1;
	logic                  pixel_s1;
	logic [PIXEL_BITS-1:0] addr_s1;
	rd_info_t              info_s1;
	logic                  fwd_s1;
	logic [COUNT_BITS-1:0] fwd_cnt_s1;

	logic                  retire_s1;
	logic [COUNT_BITS-1:0] rd_data;
	logic [COUNT_BITS-1:0] cnt_s1;
	logic [COUNT_BITS-1:0] new_cnt;
	logic                  pix_wr;

	logic                  wr_en;
	logic [PIXEL_BITS-1:0] wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic [PIXEL_BITS-1:0] rd_addr;

	stats_upd_t upd;
	rd_info_t   info;

	logic res_valid_q;
	rsp_t res_q;

	assign is_pixel = req.cmd == CMD_PIXEL;
	assign is_read  = req.cmd == CMD_READ;
	assign is_clear = req.cmd == CMD_CLEAR;

	assign retire_s1 = valid_s1 && (pixel_s1 || !res_valid_q || res_ready);
	assign req_ready = !clr_busy_q && (!valid_s1 || retire_s1);
	assign accept    = req_valid && req_ready;

	always_comb begin
		upd.clear       = accept && is_clear;
		upd.pixel       = accept && is_pixel;
		upd.pixel_value = req.pixel_value;
	end

	shmm_stats u_stats (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.bin_offset (req.bin_offset),
		.info       (info)
	);

	assign rd_addr = is_pixel ? req.pixel_value : info.bin_value;

	// bump stage
	assign cnt_s1  = fwd_s1 ? fwd_cnt_s1 : rd_data;
	assign new_cnt = (cnt_s1 == COUNT_MAX) ? cnt_s1 : cnt_s1 + 1'b1;
	assign pix_wr  = valid_s1 && pixel_s1;

	assign wr_en   = clr_busy_q || pix_wr;
	assign wr_addr = clr_busy_q ? clr_addr_q : addr_s1;
	assign wr_data = clr_busy_q ? '0 : new_cnt;

	shmm_bin_ram #(
		.ADDR_BITS (PIXEL_BITS),
		.DATA_BITS (COUNT_BITS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept && (is_pixel || is_read)),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (accept && is_clear) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {PIXEL_BITS{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && (is_pixel || is_read)) begin
			valid_s1 <= 1'b1;
		end else if (retire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1   <= is_pixel;
			addr_s1    <= rd_addr;
			info_s1    <= info;
			// the bump in flight lands on the same edge as this read
			fwd_s1     <= pix_wr && (addr_s1 == rd_addr);
			fwd_cnt_s1 <= new_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (retire_s1 && !pixel_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire_s1 && !pixel_s1) begin
			res_q.bin_value      <= info_s1.bin_value;
			res_q.bin_count      <= info_s1.out_of_range ? '0 : cnt_s1;
			res_q.slice_minimum  <= info_s1.slice_minimum;
			res_q.slice_maximum  <= info_s1.slice_maximum;
			res_q.number_of_bins <= info_s1.number_of_bins;
			res_q.out_of_range   <= info_s1.out_of_range;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/shmm_bin_ram.sv -----
`default_nettype none

module shmm_bin_ram
	import shmm_pkg::*;
#(
	parameter int ADDR_BITS = PIXEL_BITS,
	parameter int DATA_BITS = COUNT_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [ADDR_BITS-1:0] wr_addr,
	input  wire logic [DATA_BITS-1:0] wr_data,
	input  wire logic                 rd_en,
	input  wire logic [ADDR_BITS-1:0] rd_addr,
	output logic      [DATA_BITS-1:0] rd_data
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [DATA_BITS-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read-before-write: same-address hazards are forwarded by the caller
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/shmm_stats.sv -----
`default_nettype none

module shmm_stats
	import shmm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire stats_upd_t            upd,
	input  wire logic [PIXEL_BITS-1:0] bin_offset,
	output rd_info_t                   info
);

	logic [PIXEL_BITS-1:0] min_q;
	logic [PIXEL_BITS-1:0] max_q;
	logic                  seen_q;
	logic [PIXEL_BITS-1:0] span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= '0;
			max_q  <= '0;
			seen_q <= 1'b0;
		end else if (upd.clear) begin
			min_q  <= '0;
			max_q  <= '0;
			seen_q <= 1'b0;
		end else if (upd.pixel) begin
			seen_q <= 1'b1;
			if (!seen_q || upd.pixel_value < min_q) begin
				min_q <= upd.pixel_value;
			end
			if (!seen_q || upd.pixel_value > max_q) begin
				max_q <= upd.pixel_value;
			end
		end
	end

	assign span = max_q - min_q;

	always_comb begin
		info.bin_value      = min_q + bin_offset;
		info.slice_minimum  = min_q;
		info.slice_maximum  = max_q;
		info.number_of_bins = {1'b0, span} + {{PIXEL_BITS{1'b0}}, 1'b1};
		info.out_of_range   = bin_offset > span;
	end

endmodule

`default_nettype wire
